/* src/imu_pkg.sv */
// ----------------------------------------------------------------------------
// IMU tilt and heading package
// Shared widths, the CORDIC angle table and the lane control type.
// ----------------------------------------------------------------------------
package imu_pkg;

  localparam int CordicIterations = 16;
  localparam int IterW = 5;
  localparam int CordicW = 36;
  localparam int AngleW = 28;
  localparam int SumW = 33;
  localparam int SqrtW = 25;
  localparam int YawW = 25;
  localparam int GainW = 23;
  localparam logic [YawW-1:0] FullTurn = 25'd23592960;
  localparam logic [16:0] AngleLimit = 17'd23040;

  function automatic logic [AngleW-1:0] atan_entry(input logic [IterW-1:0] i);
    logic [AngleW-1:0] v;
    unique case (i)
      5'd0: v = 28'd2949120;
      5'd1: v = 28'd1740967;
      5'd2: v = 28'd919879;
      5'd3: v = 28'd466945;
      5'd4: v = 28'd234379;
      5'd5: v = 28'd117304;
      5'd6: v = 28'd58666;
      5'd7: v = 28'd29335;
      5'd8: v = 28'd14668;
      5'd9: v = 28'd7334;
      5'd10: v = 28'd3667;
      5'd11: v = 28'd1833;
      5'd12: v = 28'd917;
      5'd13: v = 28'd458;
      5'd14: v = 28'd229;
      5'd15: v = 28'd115;
      5'd16: v = 28'd57;
      5'd17: v = 28'd29;
      5'd18: v = 28'd14;
      5'd19: v = 28'd7;
      5'd20: v = 28'd4;
      5'd21: v = 28'd2;
      5'd22: v = 28'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic start;
    logic done;
  } lane_ctl_t;

endpackage

/* src/imu_tilt_lane.sv */
// ----------------------------------------------------------------------------
// IMU tilt lane
// Computes atan2(a, sqrt(b^2+c^2)) in 1/256 degree: a bit-serial square
// root, then a single CORDIC stage iterated in vectoring mode.
// ----------------------------------------------------------------------------
module imu_tilt_lane import imu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  input  logic signed [15:0] c,
  output logic               done,
  output logic signed [15:0] angle
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SQ   = 4'b0010,
    S_SQRT = 4'b0100,
    S_CORD = 4'b1000
  } state_t;

  state_t state;
  logic [4:0] cnt;
  logic signed [31:0] bb, cc;
  logic [2*SqrtW-1:0] rem_v;
  logic [SqrtW-1:0] root;
  logic [2*SqrtW-1:0] rad;
  logic signed [CordicW-1:0] x, y;
  logic signed [AngleW-1:0] z;
  logic signed [CordicW-1:0] xs, ys;
  logic [SqrtW+1:0] trial;
  logic [SqrtW+1:0] rem_hi;
  logic [AngleW-1:0] mag;
  logic [AngleW-9:0] rnd;
  logic [16:0] sat;
  logic signed [15:0] ang_c;

  assign xs = x >>> (cnt - 5'd1);
  assign ys = y >>> (cnt - 5'd1);
  assign rem_hi = {rem_v[SqrtW-1:0], rad[2*SqrtW-1 -: 2]};
  assign trial = {root, 2'b01};
  assign mag = z[AngleW-1] ? AngleW'(-z) : AngleW'(z);
  assign rnd = (AngleW-8)'((mag + AngleW'(128)) >> 8);
  assign sat = (rnd > (AngleW-8)'(AngleLimit)) ? AngleLimit : 17'(rnd);
  assign ang_c = z[AngleW-1] ? 16'(-sat) : 16'(sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      done <= 1'b0;
      angle <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            bb <= b * b;
            cc <= c * c;
            y <= CordicW'(a) <<< 8;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          rad <= {1'b0, ({1'b0, bb} + {1'b0, cc}), 16'd0};
          rem_v <= '0;
          root <= '0;
          cnt <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (rem_hi >= trial) begin
            rem_v <= (2*SqrtW)'(rem_hi - trial);
            root <= {root[SqrtW-2:0], 1'b1};
          end else begin
            rem_v <= (2*SqrtW)'(rem_hi);
            root <= {root[SqrtW-2:0], 1'b0};
          end
          rad <= rad << 2;
          if (cnt == 5'(SqrtW-1)) begin
            cnt <= '0;
            z <= '0;
            state <= S_CORD;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_CORD: begin
          if (cnt == 5'd0) begin
            x <= CordicW'({1'b0, root});
            cnt <= 5'd1;
            if (y == '0) begin
              angle <= '0;
              done <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            if (!y[CordicW-1] && y != '0) begin
              x <= x + ys;
              y <= y - xs;
              z <= z + atan_entry(cnt - 5'd1);
            end else begin
              x <= x - ys;
              y <= y + xs;
              z <= z - atan_entry(cnt - 5'd1);
            end
            if (cnt == 5'(CordicIterations)) begin
              state <= S_IDLE;
              cnt <= 5'd31;
            end else begin
              cnt <= cnt + 5'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE && cnt == 5'd31) begin
        cnt <= '0;
        angle <= ang_c;
        done <= 1'b1;
      end
    end
  end

endmodule

/* src/imu_yaw.sv */
// ----------------------------------------------------------------------------
// IMU yaw integrator
// Scales the gyro rate by the gain and wraps the accumulator into one turn.
// ----------------------------------------------------------------------------
module imu_yaw import imu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lane_ctl_t          ctl,
  input  logic signed [15:0] gz,
  input  logic               en,
  input  logic [GainW-1:0]   gain,
  output logic [YawW-1:0]    yaw
);

  logic signed [39:0] prod;
  logic signed [YawW+1:0] sum;
  logic signed [YawW+1:0] sum_w;
  logic upd;

  assign sum_w = (sum >= $signed({2'b0, FullTurn})) ? sum - $signed({2'b0, FullTurn}) :
                 (sum < 0) ? sum + $signed({2'b0, FullTurn}) : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw <= '0;
      upd <= 1'b0;
    end else begin
      upd <= 1'b0;
      if (ctl.start) begin
        prod <= gz * $signed({1'b0, gain});
      end
      if (ctl.done && en) begin
        sum <= $signed({2'b0, yaw}) + (YawW+2)'(prod >>> 16);
        upd <= 1'b1;
      end
      if (upd) begin
        yaw <= YawW'(sum_w);
      end
    end
  end

endmodule

/* src/imu_tilt_and_heading.sv */
// ----------------------------------------------------------------------------
// IMU tilt and heading
// Each accepted item runs through the 25-step square root and the 16-step
// CORDIC in each tilt lane; the result comes sooner when both tilt
// numerators are zero.
// One item at a time: in_ready stays low until the result is taken.
// Reset clears yaw, held pitch and roll to zero and gain to 655720.
// ----------------------------------------------------------------------------
module imu_tilt_and_heading import imu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [GainW-1:0]   yaw_gain,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_z,
  input  logic               accel_ok,
  input  logic               gyro_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pitch,
  output logic signed [15:0] roll,
  output logic [16:0]        heading,
  output logic               heading_updated
);

  logic [GainW-1:0] gain;
  logic busy, aok, gok, p_done, r_done, p_seen, r_seen, fin, fin_d;
  logic signed [15:0] p_ang, r_ang, p_hold, r_hold;
  logic [YawW-1:0] yaw;
  lane_ctl_t yctl;
  logic start;

  assign cfg_ready = 1'b1;
  assign in_ready = !busy && !fin_d && !out_valid;
  assign start = in_valid && in_ready;
  assign fin = busy && (p_seen || p_done) && (r_seen || r_done);
  assign yctl = '{start: start, done: fin};

  imu_tilt_lane u_pitch (
    .clk(clk), .rst(rst), .start(start),
    .a(accel_x), .b(accel_y), .c(accel_z), .done(p_done), .angle(p_ang));

  imu_tilt_lane u_roll (
    .clk(clk), .rst(rst), .start(start),
    .a(accel_y), .b(accel_x), .c(accel_z), .done(r_done), .angle(r_ang));

  imu_yaw u_yaw (
    .clk(clk), .rst(rst), .ctl(yctl), .gz(gyro_z), .en(gok),
    .gain(gain), .yaw(yaw));

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= 23'd655720;
      busy <= 1'b0;
      p_seen <= 1'b0;
      r_seen <= 1'b0;
      fin_d <= 1'b0;
      out_valid <= 1'b0;
      p_hold <= '0;
      r_hold <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gain <= yaw_gain;
      end
      fin_d <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        aok <= accel_ok;
        gok <= gyro_ok;
      end
      if (p_done) begin
        p_seen <= 1'b1;
        if (aok) p_hold <= p_ang;
      end
      if (r_done) begin
        r_seen <= 1'b1;
        if (aok) r_hold <= r_ang;
      end
      if (fin) begin
        busy <= 1'b0;
        p_seen <= 1'b0;
        r_seen <= 1'b0;
        fin_d <= 1'b1;
      end
      if (fin_d) begin
        out_valid <= 1'b1;
        heading_updated <= gok;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pitch = p_hold;
  assign roll = r_hold;
  assign heading = yaw[YawW-1:8];

endmodule
